// File: sv/vrs_pkg.sv
`timescale 1ns / 1ps

package vrs_pkg;

	// Sizes
	localparam int FRAME_BITS      = 20;
	localparam int PITCH_FRAC_BITS = 8;
	localparam int PITCH_BITS      = 15;
	localparam int OUT_BITS        = 20;
	localparam int GAP_CMP_BITS    = (FRAME_BITS > 8) ? FRAME_BITS : 8;
	localparam int ALPHA_SHIFT     = 10;

	localparam logic [FRAME_BITS-1:0] FRAME_MAX = {FRAME_BITS{1'b1}};

	// Register reset values
	localparam logic [7:0]  MAX_GAP_RST   = 8'd8;
	localparam logic [14:0] JUMP_THR_RST  = 15'((5 << PITCH_FRAC_BITS) / 2);
	localparam logic [7:0]  JUMP_GAP_RST  = 8'd2;
	localparam logic [10:0] SMOOTHING_RST = 11'd102;

	// Register indexes
	typedef enum logic [1:0] {
		CFG_MAX_GAP   = 2'd0,
		CFG_JUMP_THR  = 2'd1,
		CFG_JUMP_GAP  = 2'd2,
		CFG_SMOOTHING = 2'd3
	} cfg_idx_t;

	// Input commands
	localparam logic CMD_FRAME = 1'b0;
	localparam logic CMD_FLUSH = 1'b1;

	typedef struct packed {
		logic [7:0]  max_gap;
		logic [14:0] jump_threshold;
		logic [7:0]  jump_gap;
		logic [10:0] smoothing;
	} cfg_t;

	typedef struct packed {
		logic        command;
		logic        voiced;
		logic [14:0] pitch;
	} in_t;

	typedef struct packed {
		logic [OUT_BITS-1:0] region_start;
		logic [OUT_BITS-1:0] region_end;
		logic                from_flush;
	} out_t;

endpackage

// File: sv/vrs_in_reg.sv
`timescale 1ns / 1ps

module vrs_in_reg
	import vrs_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  in_t  in_data,
	input  logic take,
	output logic valid_s1,
	output in_t  data_s1
);

	// Holding register; refills in the cycle the core consumes it
	assign in_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= in_data;
		end
	end

endmodule

// File: sv/vrs_core.sv
`timescale 1ns / 1ps

module vrs_core
	import vrs_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  logic fire,
	input  in_t  item,
	output logic res_valid,
	output out_t res
);

	logic [FRAME_BITS-1:0] frame_q, begin_q, last_q;
	logic                  open_q, lvv_q;
	logic [14:0]           ref_q;

	logic [FRAME_BITS-1:0] frame_d, begin_d, last_d;
	logic                  open_d, lvv_d;
	logic [14:0]           ref_d;

	logic [FRAME_BITS-1:0] gap;
	logic                  gap_long, gap_short, jump_big, split;
	logic signed [15:0]    diff;
	logic [15:0]           abs_diff;
	logic [14:0]           jump;
	logic signed [27:0]    prod;
	logic signed [17:0]    step;
	logic signed [18:0]    ref_sum;
	logic [14:0]           ref_smooth;
	logic [FRAME_BITS-1:0] emit_last;
	logic [FRAME_BITS-1:0] end_val;

	// Region end: one past last, saturating, never below start + 1
	function automatic logic [FRAME_BITS-1:0] region_end_of(
		input logic [FRAME_BITS-1:0] start,
		input logic [FRAME_BITS-1:0] last
	);
		logic [FRAME_BITS-1:0] e;
		e = (last < FRAME_MAX) ? last + 1'b1 : FRAME_MAX;
		if ((start < FRAME_MAX) && (e <= start)) begin
			e = start + 1'b1;
		end
		return e;
	endfunction

	// Gap and pitch jump
	assign gap       = lvv_q ? frame_q - last_q : '0;
	assign gap_long  = GAP_CMP_BITS'(gap) > GAP_CMP_BITS'(cfg.max_gap);
	assign gap_short = GAP_CMP_BITS'(gap) <= GAP_CMP_BITS'(cfg.jump_gap);
	assign diff      = $signed({1'b0, item.pitch}) - $signed({1'b0, ref_q});
	assign abs_diff  = diff[15] ? 16'(-diff) : 16'(diff);
	assign jump      = (ref_q != '0) ? abs_diff[14:0] : '0;
	assign jump_big  = jump > cfg.jump_threshold;
	assign split     = open_q && (gap_long || (jump_big && gap_short));

	// Reference smoothing, floor shift, clamped to the pitch range
	assign prod       = 28'(diff * $signed({1'b0, cfg.smoothing}));
	assign step       = prod[27:ALPHA_SHIFT];
	assign ref_sum    = $signed({4'b0, ref_q}) + 19'(step);
	assign ref_smooth = ref_sum[18] ? '0 : ((ref_sum[17:15] != '0) ? '1 : ref_sum[14:0]);

	assign emit_last = (item.voiced && !lvv_q) ? begin_q : last_q;
	assign end_val   = region_end_of(begin_q, emit_last);

	// Next state and result
	always_comb begin
		frame_d   = (frame_q < FRAME_MAX) ? frame_q + 1'b1 : frame_q;
		begin_d   = begin_q;
		open_d    = open_q;
		last_d    = last_q;
		lvv_d     = lvv_q;
		ref_d     = ref_q;
		res_valid = 1'b0;
		res.region_start = OUT_BITS'(begin_q);
		res.region_end   = OUT_BITS'(end_val);
		res.from_flush   = 1'b0;
		if (item.command == CMD_FLUSH) begin
			res_valid      = open_q && lvv_q && (last_q >= begin_q);
			res.from_flush = 1'b1;
			frame_d = '0;
			begin_d = '0;
			open_d  = 1'b0;
			last_d  = '0;
			lvv_d   = 1'b0;
			ref_d   = '0;
		end else if (item.voiced) begin
			res_valid = split;
			if (split || !open_q) begin
				open_d  = 1'b1;
				begin_d = frame_q;
				ref_d   = item.pitch;
			end else begin
				ref_d = ref_smooth;
			end
			last_d = frame_q;
			lvv_d  = 1'b1;
		end else if (open_q && lvv_q && gap_long) begin
			res_valid = 1'b1;
			open_d    = 1'b0;
			lvv_d     = 1'b0;
			last_d    = '0;
			ref_d     = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q <= '0;
			begin_q <= '0;
			open_q  <= 1'b0;
			last_q  <= '0;
			lvv_q   <= 1'b0;
			ref_q   <= '0;
		end else if (fire) begin
			frame_q <= frame_d;
			begin_q <= begin_d;
			open_q  <= open_d;
			last_q  <= last_d;
			lvv_q   <= lvv_d;
			ref_q   <= ref_d;
		end
	end

endmodule

// File: sv/vrs_out_reg.sv
`timescale 1ns / 1ps

module vrs_out_reg
	import vrs_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic load,
	input  out_t load_data,
	output logic free,
	output logic out_valid,
	input  logic out_ready,
	output out_t out_data
);

	// Result register; a new result may replace one being taken
	assign free = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (free) begin
			out_valid <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load) begin
			out_data <= load_data;
		end
	end

endmodule

// File: sv/voiced_region_segmenter.sv
`timescale 1ns / 1ps
// Channel   Signals                        Moves
// input     in_valid / in_ready / in_data  one frame or flush command
// output    out_valid / out_ready / out_data  one closed region
// config    cfg_we / cfg_index / cfg_data  one register write, no wait
//
// One item per cycle sustained while the output is not stalled; an accepted
// input waits in the input register and its result in the result register.
// The state update (compares, one 16x12 multiply, clamp) sits between the
// input register and the result register.
// Reset clears the segmenter state and loads the register defaults.
// A stalled result holds the core at once; the input stalls once the input
// register is also full.

module voiced_region_segmenter
	import vrs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_t         in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_t        out_data,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [14:0] cfg_data
);

	cfg_t cfg_q;
	logic valid_s1;
	in_t  data_s1;
	logic out_free;
	logic fire;
	logic res_valid;
	out_t res;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_gap        <= MAX_GAP_RST;
			cfg_q.jump_threshold <= JUMP_THR_RST;
			cfg_q.jump_gap       <= JUMP_GAP_RST;
			cfg_q.smoothing      <= SMOOTHING_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_MAX_GAP:   cfg_q.max_gap        <= cfg_data[7:0];
				CFG_JUMP_THR:  cfg_q.jump_threshold <= cfg_data;
				CFG_JUMP_GAP:  cfg_q.jump_gap       <= cfg_data[7:0];
				CFG_SMOOTHING: cfg_q.smoothing      <= cfg_data[10:0];
				default:       cfg_q                <= cfg_q;
			endcase
		end
	end

	// Core consumes the held item whenever the result register can take it
	assign fire = valid_s1 && out_free;

	vrs_in_reg u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.take     (fire),
		.valid_s1 (valid_s1),
		.data_s1  (data_s1)
	);

	vrs_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.fire      (fire),
		.item      (data_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	vrs_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (fire && res_valid),
		.load_data (res),
		.free      (out_free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// File: sim/tb_voiced_region_segmenter.sv
`timescale 1ns / 1ps

module tb_voiced_region_segmenter;
	import vrs_pkg::*;

	localparam int CYCLE_LIMIT = 600000;
	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 210;

	// Tracks the open region the way the segmenter should and queues the closed
	// regions it expects to see, oldest first.
	class region_checker;
		cfg_t                  cfg;
		logic [FRAME_BITS-1:0] frame_cnt;
		logic [FRAME_BITS-1:0] open_start;
		logic [FRAME_BITS-1:0] last_voiced_frame;
		bit                    region_live;
		bit                    last_live;
		int                    ref_pitch;
		out_t                  regions_due[$];
		int                    mismatches;

		function new();
			cfg = '{MAX_GAP_RST, JUMP_THR_RST, JUMP_GAP_RST, SMOOTHING_RST};
			mismatches = 0;
			clear_track();
		endfunction

		function void clear_track();
			frame_cnt         = '0;
			open_start        = '0;
			last_voiced_frame = '0;
			region_live       = 1'b0;
			last_live         = 1'b0;
			ref_pitch         = 0;
		endfunction

		function void write_reg(cfg_idx_t idx, logic [14:0] val);
			case (idx)
				CFG_MAX_GAP:   cfg.max_gap        = val[7:0];
				CFG_JUMP_THR:  cfg.jump_threshold = val[14:0];
				CFG_JUMP_GAP:  cfg.jump_gap       = val[7:0];
				CFG_SMOOTHING: cfg.smoothing      = val[10:0];
				default: ;
			endcase
		endfunction

		// End is one past the last voiced frame, held at the counter ceiling
		function void close_region(logic [FRAME_BITS-1:0] start, logic [FRAME_BITS-1:0] last,
				logic flush);
			longint stop;
			out_t   r;
			stop = (last < FRAME_MAX) ? longint'(last) + 1 : longint'(FRAME_MAX);
			if (stop < longint'(start) + 1 && start < FRAME_MAX)
				stop = longint'(start) + 1;
			r.region_start = start[OUT_BITS-1:0];
			r.region_end   = stop[OUT_BITS-1:0];
			r.from_flush   = flush;
			regions_due = {regions_due, r};
		endfunction

		// ref + floor((p - ref) * alpha / 1024), clamped to the pitch range
		function int smoothed(int r, int p);
			longint prod;
			longint nxt;
			prod = longint'(p - r) * longint'(cfg.smoothing);
			nxt  = longint'(r) + (prod >>> ALPHA_SHIFT);
			if (nxt < 0)
				nxt = 0;
			if (nxt > 32767)
				nxt = 32767;
			return int'(nxt);
		endfunction

		// Called for every accepted input transaction
		function void note_frame(in_t item);
			logic [FRAME_BITS-1:0] now_frame;
			int unsigned           gap;
			int                    pitch_v;
			int                    jump;
			now_frame = frame_cnt;
			pitch_v   = int'(item.pitch);

			if (item.command == CMD_FLUSH) begin
				if (region_live && last_live && last_voiced_frame >= open_start)
					close_region(open_start, last_voiced_frame, 1'b1);
				clear_track();
				return;
			end

			if (item.voiced) begin
				gap = last_live ? int'(now_frame - last_voiced_frame) : 0;
				// a zero reference means none, so no jump against it
				if (ref_pitch > 0)
					jump = (pitch_v > ref_pitch) ? pitch_v - ref_pitch : ref_pitch - pitch_v;
				else
					jump = 0;
				if (region_live && (gap > cfg.max_gap ||
						(jump > cfg.jump_threshold && gap <= cfg.jump_gap))) begin
					close_region(open_start, last_live ? last_voiced_frame : open_start, 1'b0);
					region_live = 1'b0;
				end
				if (!region_live) begin
					region_live = 1'b1;
					open_start  = now_frame;
					ref_pitch   = pitch_v;
				end else begin
					ref_pitch = smoothed(ref_pitch, pitch_v);
				end
				last_voiced_frame = now_frame;
				last_live         = 1'b1;
			end else if (region_live && last_live &&
					(now_frame - last_voiced_frame) > cfg.max_gap) begin
				// silence ran too long
				close_region(open_start, last_voiced_frame, 1'b0);
				region_live       = 1'b0;
				last_live         = 1'b0;
				last_voiced_frame = '0;
				ref_pitch         = 0;
			end

			if (frame_cnt != FRAME_MAX)
				frame_cnt++;
		endfunction

		task report(string msg);
			$display("[%0t] MISMATCH: %s", $time, msg);
			mismatches++;
		endtask

		// Called for every accepted output transaction
		task check_region(out_t got);
			out_t want;
			if (regions_due.size() == 0) begin
				report($sformatf("unexpected region start=%0d end=%0d flush=%0b",
					got.region_start, got.region_end, got.from_flush));
				return;
			end
			want = regions_due.pop_front();
			if (got.region_start !== want.region_start)
				report($sformatf("region_start got %0d want %0d",
					got.region_start, want.region_start));
			if (got.region_end !== want.region_end)
				report($sformatf("region_end got %0d want %0d (start %0d)",
					got.region_end, want.region_end, want.region_start));
			if (got.from_flush !== want.from_flush)
				report($sformatf("from_flush got %0b want %0b (start %0d)",
					got.from_flush, want.from_flush, want.region_start));
		endtask
	endclass

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_ready;
	in_t         in_data   = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	out_t        out_data;
	logic        cfg_we    = 1'b0;
	logic [1:0]  cfg_index = CFG_MAX_GAP;
	logic [14:0] cfg_data  = '0;

	region_checker sb = new();

	int   cycle_count = 0;
	int   rx_tick     = 0;
	int   rx_mode     = 0;
	int   burst_left  = 0;
	cfg_t phase_cfg[PHASES];

	voiced_region_segmenter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #10 clk = ~clk;

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Receiver: ready pattern switches between free-running, coin flip,
	// mostly stalled and a fixed duty cycle
	always @(posedge clk) begin
		rx_tick++;
		if (rx_tick % 173 == 0)
			rx_mode = $urandom_range(0, 3);
		case (rx_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= 1'($urandom_range(0, 1));
			2: out_ready <= ($urandom_range(0, 7) == 0);
			default: out_ready <= ((rx_tick % 7) < 4);
		endcase
	end

	// Output monitor
	always @(posedge clk) begin
		if (out_valid === 1'b1 && out_ready === 1'b1)
			sb.check_region(out_data);
	end

	function automatic in_t mk_item(logic cmd, logic voiced, logic [14:0] pitch);
		in_t item;
		item.command = cmd;
		item.voiced  = voiced;
		item.pitch   = pitch;
		return item;
	endfunction

	// Sends one transaction; the sender may pause between bursts of random length
	task automatic send_item(in_t item);
		int pause;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			pause = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (pause > 0) begin
				in_valid <= 1'b0;
				repeat (pause) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		in_data  <= item;
		do
			@(posedge clk);
		while (in_ready !== 1'b1);
		sb.note_frame(item);
	endtask

	// Stop sending, wait for every expected region, then let the pipe settle
	task automatic drain();
		int waited;
		waited = 0;
		in_valid <= 1'b0;
		burst_left = 0;
		while (sb.regions_due.size() != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		repeat (8) @(posedge clk);
	endtask

	task automatic apply_settings(cfg_t s);
		cfg_idx_t    idx;
		logic [14:0] val;
		for (int k = 0; k < 4; k++) begin
			idx = cfg_idx_t'(k);
			case (idx)
				CFG_MAX_GAP:   val = 15'(s.max_gap);
				CFG_JUMP_THR:  val = s.jump_threshold;
				CFG_JUMP_GAP:  val = 15'(s.jump_gap);
				default:       val = 15'(s.smoothing);
			endcase
			cfg_we    <= 1'b1;
			cfg_index <= idx;
			cfg_data  <= val;
			@(posedge clk);
			sb.write_reg(idx, val);
		end
		cfg_we <= 1'b0;
	endtask

	// Hand-picked sequence under the reset settings
	task automatic run_directed();
		send_item(mk_item(CMD_FRAME, 1'b0, 15'h7FFF));  // silence, nothing open
		send_item(mk_item(CMD_FRAME, 1'b1, 15'h3C00));  // opens a region
		send_item(mk_item(CMD_FRAME, 1'b1, 15'h3C80));  // small move, smoothing
		send_item(mk_item(CMD_FRAME, 1'b1, 15'h7FFF));  // jump splits
		send_item(mk_item(CMD_FRAME, 1'b1, 15'h0000));  // jump to zero pitch
		send_item(mk_item(CMD_FRAME, 1'b1, 15'h1000));  // zero reference: no jump
		repeat (9) send_item(mk_item(CMD_FRAME, 1'b0, 15'h5555));  // long silence closes
		send_item(mk_item(CMD_FRAME, 1'b1, 15'h0001));
		send_item(mk_item(CMD_FLUSH, 1'b1, 15'h7FFF));  // flush closes open region
		send_item(mk_item(CMD_FLUSH, 1'b0, 15'h0000));  // flush with nothing open
		send_item(mk_item(CMD_FRAME, 1'b1, 15'h0100));
		repeat (3) send_item(mk_item(CMD_FRAME, 1'b0, 15'h0000));
		send_item(mk_item(CMD_FRAME, 1'b1, 15'h7000));  // jump, gap too wide to split
		send_item(mk_item(CMD_FLUSH, 1'b0, 15'h2AAA));
	endtask

	// Phrases of voiced frames with wobble and jumps, silences placed around
	// the gap limits, flushes, and some fully random frames
	task automatic run_random(int target);
		int sent;
		int kind;
		int len;
		int base;
		int p;
		int step;
		int quiet;
		int thr;
		int mg;
		int jg;
		sent = 0;
		while (sent < target) begin
			kind = $urandom_range(0, 99);
			thr  = int'(sb.cfg.jump_threshold);
			mg   = int'(sb.cfg.max_gap);
			jg   = int'(sb.cfg.jump_gap);
			if (kind < 68) begin
				len  = $urandom_range(1, 12);
				base = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32767)
					: $urandom_range(9000, 21000);
				for (int k = 0; k < len; k++) begin
					p = base + int'($urandom_range(0, 128)) - 64;
					if ($urandom_range(0, 9) == 0) begin
						step = $urandom_range(thr / 2, thr * 2 + 2);
						if ($urandom_range(0, 1) == 0)
							base = base - step;
						else
							base = base + step;
						if (base < 0)
							base = 0;
						if (base > 32767)
							base = 32767;
						p = base;
					end
					if ($urandom_range(0, 49) == 0)
						p = 0;
					if (p < 0)
						p = 0;
					if (p > 32767)
						p = 32767;
					send_item(mk_item(CMD_FRAME, 1'b1, p[14:0]));
					sent++;
				end
				case ($urandom_range(0, 6))
					0: quiet = 0;
					1: quiet = jg - 1;
					2: quiet = jg;
					3: quiet = mg - 1;
					4: quiet = mg;
					5: quiet = mg + 1;
					default: quiet = $urandom_range(0, 12);
				endcase
				if (quiet < 0)
					quiet = 0;
				if (quiet > 40 && $urandom_range(0, 9) != 0)
					quiet = $urandom_range(0, 40);
				for (int k = 0; k < quiet; k++) begin
					send_item(mk_item(CMD_FRAME, 1'b0, 15'($urandom_range(0, 32767))));
					sent++;
				end
			end else if (kind < 78) begin
				send_item(mk_item(CMD_FLUSH, 1'($urandom_range(0, 1)),
					15'($urandom_range(0, 32767))));
				sent++;
			end else begin
				len = $urandom_range(1, 8);
				for (int k = 0; k < len; k++) begin
					send_item(mk_item(CMD_FRAME, 1'($urandom_range(0, 1)),
						15'($urandom_range(0, 32767))));
					sent++;
				end
			end
		end
	endtask

	initial begin
		phase_cfg[0] = '{MAX_GAP_RST, JUMP_THR_RST, JUMP_GAP_RST, SMOOTHING_RST};
		phase_cfg[1] = '{8'd0, 15'd0, 8'd0, 11'd0};
		phase_cfg[2] = '{8'd255, 15'd32767, 8'd255, 11'd1024};
		phase_cfg[3] = '{8'd255, 15'd0, 8'd1, 11'd2047};
		phase_cfg[4] = '{8'd3, 15'd100, 8'd3, 11'd1536};
		phase_cfg[5] = '{8'd1, 15'd1, 8'd1, 11'd1};
		for (int i = 6; i < PHASES; i++) begin
			phase_cfg[i].max_gap        = 8'($urandom_range(0, 20));
			phase_cfg[i].jump_threshold = 15'($urandom_range(0, 2000));
			phase_cfg[i].jump_gap       = 8'($urandom_range(0, 6));
			phase_cfg[i].smoothing      = 11'($urandom_range(0, 2047));
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < PHASES; i++) begin
			apply_settings(phase_cfg[i]);
			if (i == 0)
				run_directed();
			run_random(PHASE_ITEMS);
			drain();
		end

		if (sb.regions_due.size() != 0)
			sb.report($sformatf("%0d expected regions never came out",
				sb.regions_due.size()));
		if (sb.mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
